// ===== rtl/keyed_sum_table_sorted_emit_macros.svh =====
// ----------------------------------------------------------------------------
// keyed_sum_table_sorted_emit assertion macros
// Shorthand for clocked properties on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_SUM_TABLE_SORTED_EMIT_MACROS_SVH
`define KEYED_SUM_TABLE_SORTED_EMIT_MACROS_SVH

// same-cycle implication
`define KST_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Types and constants shared by the keyed sum table blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int KEY_W = 24;
    localparam int AMT_W = 32;
    localparam int TOT_W = 48;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
    localparam logic [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

    typedef struct packed {
        logic                    operation;
        logic [KEY_W-1:0]        currency_key;
        logic signed [AMT_W-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]        out_key;
        logic signed [TOT_W-1:0] out_total;
        logic                    entry_valid;
        logic                    overflow_seen;
        logic                    last_result;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic pick;
        logic upd_total;
        logic append;
        logic emit_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic scan_done;
        logic out_free;
        logic last_rank;
        logic empty;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/kst_ctrl.sv =====
// ----------------------------------------------------------------------------
// kst_ctrl
// Sequencer for table search, update, append and sorted emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kst_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_op,
    output kst_pkg::cmd_t      cmd,
    input  wire kst_pkg::sts_t sts
);
    import kst_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_op == OP_EMIT) ? ST_SCAN : ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.scan = 1'b1;
                if (sts.hit) begin
                    cmd.upd_total = 1'b1;
                    state_next    = ST_IDLE;
                end else if (sts.scan_done) begin
                    cmd.append = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                cmd.pick = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (sts.last_rank) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kst_dpath.sv =====
// ----------------------------------------------------------------------------
// kst_dpath
// Key and total memories, scan pipeline, max pick and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kst_dpath #(
    parameter int ENTRIES = kst_pkg::ENTRIES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire kst_pkg::in_item_t s_payload,
    input  wire kst_pkg::cmd_t     cmd,
    output kst_pkg::sts_t          sts,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output kst_pkg::out_item_t     m_payload
);
    import kst_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [KEY_W-1:0] key_mem [ENTRIES];
    logic [TOT_W-1:0] total_mem [ENTRIES];

    logic [KEY_W-1:0] key_reg;
    logic [AMT_W-1:0] amt_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [KEY_W-1:0] rd_key_reg;
    logic [TOT_W-1:0] rd_total_reg;
    logic [CNT_W-1:0] rank_reg, rank_next;
    logic [ENTRIES-1:0] done_reg, done_next;
    logic             best_vld_reg, best_vld_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [TOT_W-1:0] best_total_reg;
    logic             m_valid_reg, m_valid_next;
    out_item_t        out_reg;

    logic             issue;
    logic             full;
    logic             pick_en;
    logic [CNT_W:0]   rank_p1;
    logic [TOT_W:0]   sum_w;
    logic [TOT_W-1:0] sat_total;

    assign issue   = cmd.scan && (ptr_reg < count_reg);
    assign full    = (count_reg == CNT_W'(ENTRIES));
    assign rank_p1 = {1'b0, rank_reg} + (CNT_W+1)'(1);
    assign pick_en = cmd.pick && rd_vld_reg && !done_reg[rd_idx_reg] &&
                     (!best_vld_reg || ($signed(rd_total_reg) > $signed(best_total_reg)));

    always_comb begin
        sum_w = {rd_total_reg[TOT_W-1], rd_total_reg} +
                {{(TOT_W+1-AMT_W){amt_reg[AMT_W-1]}}, amt_reg};
        if (sum_w[TOT_W] != sum_w[TOT_W-1]) begin
            sat_total = sum_w[TOT_W] ? TOT_MIN : TOT_MAX;
        end else begin
            sat_total = sum_w[TOT_W-1:0];
        end
    end

    assign sts.hit       = rd_vld_reg && (rd_key_reg == key_reg);
    assign sts.scan_done = (ptr_reg == count_reg) && !rd_vld_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.last_rank = (count_reg == '0) || (rank_p1 == {1'b0, count_reg});
    assign sts.empty     = (count_reg == '0);

    always_comb begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        ptr_next      = ptr_reg;
        rd_vld_next   = issue;
        rank_next     = rank_reg;
        done_next     = done_reg;
        best_vld_next = best_vld_reg;
        m_valid_next  = m_valid_reg;

        if (cmd.load || cmd.emit_load) begin
            ptr_next      = '0;
            best_vld_next = 1'b0;
        end else if (issue) begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
        if (pick_en) begin
            best_vld_next = 1'b1;
        end

        if (cmd.load) begin
            rank_next = '0;
            done_next = '0;
        end else if (cmd.emit_load) begin
            rank_next = rank_p1[CNT_W-1:0];
            if (best_vld_reg) begin
                done_next[best_idx_reg] = 1'b1;
            end
        end

        if (cmd.append) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.clear) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end

        if (cmd.emit_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            ptr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rank_reg     <= '0;
            done_reg     <= '0;
            best_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            ptr_reg      <= ptr_next;
            rd_vld_reg   <= rd_vld_next;
            rank_reg     <= rank_next;
            done_reg     <= done_next;
            best_vld_reg <= best_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // table memories: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.upd_total) begin
            total_mem[rd_idx_reg] <= sat_total;
        end else if (cmd.append && !full) begin
            key_mem[count_reg[IDX_W-1:0]]   <= key_reg;
            total_mem[count_reg[IDX_W-1:0]] <= {{(TOT_W-AMT_W){amt_reg[AMT_W-1]}}, amt_reg};
        end
        rd_key_reg   <= key_mem[ptr_reg[IDX_W-1:0]];
        rd_total_reg <= total_mem[ptr_reg[IDX_W-1:0]];
        rd_idx_reg   <= ptr_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= s_payload.currency_key;
            amt_reg <= s_payload.amount;
        end
        if (pick_en) begin
            best_idx_reg   <= rd_idx_reg;
            best_key_reg   <= rd_key_reg;
            best_total_reg <= rd_total_reg;
        end
        if (cmd.emit_load) begin
            out_reg.out_key       <= best_vld_reg ? best_key_reg : '0;
            out_reg.out_total     <= best_vld_reg ? best_total_reg : '0;
            out_reg.entry_valid   <= best_vld_reg;
            out_reg.overflow_seen <= ovf_reg;
            out_reg.last_result   <= sts.last_rank;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

`default_nettype wire

// ===== rtl/keyed_sum_table_sorted_emit.sv =====
// ----------------------------------------------------------------------------
// keyed_sum_table_sorted_emit: group-by-sum key table with sorted descending dump
// Add: scans the N stored entries for the key, one table read per cycle.
// Emit: per result, a full table scan for the next maximum, then a load of
//   the result register, which waits while an earlier result is held and
//   m_ready is low. Reset clears count, overflow and control state, not memories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_sum_table_sorted_emit_macros.svh"

module keyed_sum_table_sorted_emit #(
    parameter int ENTRIES = kst_pkg::ENTRIES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire kst_pkg::in_item_t s_payload,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output kst_pkg::out_item_t     m_payload
);
    import kst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    kst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_payload.operation),
        .cmd     (cmd),
        .sts     (sts)
    );

    kst_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    `KST_ASSERT_NEXT(a_emit_busy, s_valid && s_ready && (s_payload.operation == OP_EMIT), !s_ready, "emit item did not start a scan")
    `KST_ASSERT_NEXT(a_clear_empty, cmd.clear, sts.empty, "table not empty after final result")
    `KST_ASSERT_SAME(a_one_write, cmd.upd_total, !cmd.append, "update and append in one cycle")
    `KST_ASSERT_SAME(a_empty_last, m_valid && !m_payload.entry_valid, m_payload.last_result, "empty-table item not marked last")

endmodule

`default_nettype wire
